[rtl/sfms_pkg.sv]
package sfms_pkg;

  // Lanes of the needle register: one byte each.
  localparam int NEEDLE_LANES   = 8;
  localparam int LEN_W          = 4;
  localparam int LANE_W         = 3;
  localparam int IDX_W          = 16;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 64;

  localparam int MAX_NEEDLE_DEF = 8;
  localparam int MAX_TEXT_DEF   = 65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 8'd1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             too_long;
  } out_item_t;

  typedef struct packed {
    logic             shift;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage

[rtl/substring_first_match_search_core.sv]
// The result item is registered: it appears in the cycle after the accepted last byte.
// Throughput: 1 text byte per cycle while the result side is not stalled; the compare row checks the whole window
// against the needle in the same cycle that the byte shifts in.
// Reset: rst_n is synchronous, active low; clears needle registers, per-text
// state and the output valid flag. Per-text state also clears after each last byte.
module substring_first_match_search_core #(
  parameter int MAX_NEEDLE = sfms_pkg::MAX_NEEDLE_DEF,
  parameter int MAX_TEXT   = sfms_pkg::MAX_TEXT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sfms_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sfms_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfms_pkg::*;

  // Only as many window cells as the needle register has lanes can ever compare.
  localparam int NCELL = (MAX_NEEDLE < NEEDLE_LANES) ? MAX_NEEDLE : NEEDLE_LANES;
  localparam int PW    = $clog2(MAX_TEXT + 1);
  localparam int IW    = (PW > IDX_W) ? PW : IDX_W;

  // Configuration registers
  logic [CFG_DATA_W-1:0] needle_r;
  logic [LEN_W-1:0]      needle_len_r;
  logic [LEN_W-1:0]      len_eff;

  // Per-text state
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic             ovf_r, ovf_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic             accept;
  logic             over;
  logic             all_hit;
  logic             filled;
  logic [PW:0]      pos_inc;
  logic [IW-1:0]    start_full;
  cell_ctrl_t       cctrl;
  logic [7:0]       link [NCELL+1];
  logic [NCELL-1:0] hits;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the needle length to the lanes we have.
  assign len_eff = (needle_len_r > LEN_W'(NCELL)) ? LEN_W'(NCELL) : needle_len_r;

  // Bytes past the length limit only raise the overflow flag.
  assign over        = pos_r >= PW'(MAX_TEXT);
  assign cctrl.shift = accept && !over;
  assign cctrl.len   = len_eff;

  // Compare row: newest byte enters cell 0, each cell hands its byte onward.
  assign link[0] = in_data.text_byte;
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sfms_cell #(.K(k)) u_cell (
      .clk      (clk),
      .ctrl     (cctrl),
      .needle   (needle_r),
      .byte_in  (link[k]),
      .byte_out (link[k+1]),
      .hit      (hits[k])
    );
  end
  assign all_hit = &hits;

  // Enough bytes taken for a full-length compare, counting this one.
  assign pos_inc    = (PW+1)'(pos_r) + (PW+1)'(1);
  assign filled     = pos_inc >= (PW+1)'(len_eff);
  assign start_full = IW'(pos_r) + IW'(1) - IW'(len_eff);

  always_comb begin
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    ovf_nxt   = ovf_r | (accept && over);
    if (cctrl.shift) begin
      pos_nxt = pos_inc[PW-1:0];
      if (!seen_r) begin
        if (len_eff == '0) begin
          seen_nxt  = 1'b1;
          first_nxt = '0;
        end else if (filled && all_hit) begin
          seen_nxt  = 1'b1;
          first_nxt = start_full[IDX_W-1:0];
        end
      end
    end
  end

  // Result item on the last byte; hold it until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept && in_data.last_byte) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.found       = seen_nxt;
      out_data_nxt.match_index = seen_nxt ? first_nxt : '0;
      out_data_nxt.too_long    = ovf_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r     <= '0;
      needle_len_r <= '0;
      pos_r        <= '0;
      seen_r       <= 1'b0;
      first_r      <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NEEDLE_BYTES:  needle_r     <= cfg_data;
          REG_NEEDLE_LENGTH: needle_len_r <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      // Drop per-text state after the last byte.
      if (accept && in_data.last_byte) begin
        pos_r   <= '0;
        seen_r  <= 1'b0;
        first_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        seen_r  <= seen_nxt;
        first_r <= first_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/sfms_cell.sv]
module sfms_cell #(
  parameter int K = 0
) (
  input  logic                                       clk,
  input  sfms_pkg::cell_ctrl_t                       ctrl,
  input  logic [sfms_pkg::NEEDLE_LANES*8-1:0]        needle,
  input  logic [7:0]                                 byte_in,
  output logic [7:0]                                 byte_out,
  output logic                                       hit
);
  import sfms_pkg::*;

  logic [7:0]       byte_r;
  logic [LEN_W-1:0] lane_full;
  logic [LANE_W-1:0] lane;
  logic             active;

  // Window position K lines up with needle lane len-1-K.
  assign active    = LEN_W'(K) < ctrl.len;
  assign lane_full = ctrl.len - LEN_W'(K) - LEN_W'(1);
  assign lane      = lane_full[LANE_W-1:0];
  assign hit       = !active || (byte_in == needle[lane*8 +: 8]);
  assign byte_out  = byte_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

endmodule

[tb/substring_first_match_search_core_tb.sv]
module substring_first_match_search_core_tb;
  import sfms_pkg::*;

  // Window depth and the clamp applied to the needle length register.
  localparam int WIN      = MAX_NEEDLE_DEF;
  localparam int LEN_CAP  = (MAX_NEEDLE_DEF < NEEDLE_LANES) ? MAX_NEEDLE_DEF : NEEDLE_LANES;
  localparam int TEXT_CAP = MAX_TEXT_DEF;

  localparam int IDLE_PCT     = 28;
  localparam int SETTLE_CYC   = 4;
  localparam int LIMIT_CYCLES = 2_000_000;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef logic [7:0] text_t [$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  substring_first_match_search_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Search predictor: own copy of the needle registers and per-text state.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] needle_reg;
  logic [LEN_W-1:0]      needle_len_reg;
  logic [7:0]            win_bytes [WIN];   // entry 0 holds the newest byte
  int                    txt_pos;
  logic                  hit_seen;
  int                    hit_start;
  logic                  overflow_seen;

  out_item_t match_reports [$];             // search results still to come out
  out_item_t want;

  in_item_t  text_feed [$];                 // items waiting for the driver
  logic      in_took = 1'b0;
  logic      calm    = 1'b0;                // suppress idling on both sides

  int err_count   = 0;
  int texts_done  = 0;
  int found_count = 0;
  int long_count  = 0;
  int reg_writes  = 0;
  int cycles      = 0;

  function automatic int cap_len(input int l);
    return (l > LEN_CAP) ? LEN_CAP : l;
  endfunction

  task automatic clear_text();
    for (int k = 0; k < WIN; k++) win_bytes[k] = '0;
    txt_pos       = 0;
    hit_seen      = 1'b0;
    hit_start     = 0;
    overflow_seen = 1'b0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    // Unknown indexes fall through and leave both registers alone.
    if (idx == REG_NEEDLE_BYTES) needle_reg = val;
    else if (idx == REG_NEEDLE_LENGTH) needle_len_reg = val[LEN_W-1:0];
    reg_writes++;
  endtask

  task automatic search_step(input in_item_t it);
    int        len;
    logic      hit;
    out_item_t res;
    if (txt_pos >= TEXT_CAP) begin
      // Past the length cap: flag it and keep the window frozen.
      overflow_seen = 1'b1;
    end else begin
      len = cap_len(needle_len_reg);
      for (int k = WIN - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = it.text_byte;
      txt_pos++;
      if (!hit_seen) begin
        if (len == 0) begin
          // Empty needle hits at the very start.
          hit_seen  = 1'b1;
          hit_start = 0;
        end else if (txt_pos >= len) begin
          // Newest window byte lines up with the last needle lane.
          hit = 1'b1;
          for (int k = 0; k < len; k++)
            if (win_bytes[k] != needle_reg[8*(len-1-k) +: 8]) hit = 1'b0;
          if (hit) begin
            hit_seen  = 1'b1;
            hit_start = txt_pos - len;
          end
        end
      end
    end
    if (it.last_byte) begin
      res.found       = hit_seen;
      res.match_index = hit_seen ? hit_start[IDX_W-1:0] : '0;
      res.too_long    = overflow_seen;
      match_reports.insert(match_reports.size(), res);
      clear_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued items at the falling edge, hold until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) in_took <= rst_n && in_valid && in_ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      // Slot is free: advance to the next item, or idle.
      if (text_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= text_feed.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random unless a quiet stretch is running.
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // ---------------------------------------------------------------------------
  // Monitor: feed the predictor from accepted items, check result items.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      needle_reg     = '0;
      needle_len_reg = '0;
      clear_text();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) search_step(in_data);
      if (out_valid && out_ready) begin
        if (match_reports.size() == 0) begin
          $error("result item with nothing pending: found=%0d match_index=%0d too_long=%0d",
                 out_data.found, out_data.match_index, out_data.too_long);
          err_count++;
        end else begin
          want = match_reports.pop_front();
          texts_done++;
          if (want.found) found_count++;
          if (want.too_long) long_count++;
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            err_count++;
          end
          if (out_data.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index,
                   out_data.match_index);
            err_count++;
          end
          if (out_data.too_long !== want.too_long) begin
            $error("too_long: expected %0d, got %0d", want.too_long, out_data.too_long);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[substring_first_match_search_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_text(input text_t t);
    in_item_t it;
    for (int i = 0; i < t.size(); i++) begin
      it.text_byte = t[i];
      it.last_byte = (i == t.size() - 1);
      text_feed.insert(text_feed.size(), it);
    end
  endtask

  // Wait until the block has nothing left in flight, then let it settle.
  task automatic drain();
    while (text_feed.size() != 0 || in_valid || match_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random text of n bytes drawn mostly from the needle's own bytes, so that
  // partial hits and overlaps are common; plant a full or a broken copy often.
  task automatic gen_text(input int n, input logic [63:0] ndl, input int e);
    text_t t;
    int    pos;
    int    r;
    int    cut;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) t.insert(t.size(), 8'($urandom_range(255)));
      else t.insert(t.size(), ndl[8*$urandom_range(NEEDLE_LANES-1) +: 8]);
    end
    r = $urandom_range(99);
    if (e > 0 && n >= e && r < 70) begin
      pos = $urandom_range(n - e);
      // A broken copy stops one byte short of the full needle.
      cut = (r < 15) ? e - 1 : e;
      for (int j = 0; j < cut; j++) t[pos + j] = ndl[8*j +: 8];
    end
    push_text(t);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    text_t       t;
    logic [63:0] ndl;
    logic [63:0] lenw;
    logic [7:0]  a;
    logic [7:0]  b;
    int          e;
    int          n;
    int          fed;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset needle is empty: every text hits at index 0.
    t = '{8'h00};
    push_text(t);
    t = '{8'hFF, 8'h12};
    push_text(t);
    drain();

    // Three-byte needle FF 00 80 with unused upper lanes set.
    write_reg(REG_NEEDLE_BYTES, 64'hA5A5_A5A5_A580_00FF);
    write_reg(REG_NEEDLE_LENGTH, 64'd3);
    t = '{8'hFF, 8'h00, 8'h80};               // hit at the first byte
    push_text(t);
    t = '{8'h00, 8'hFF, 8'h00, 8'h80};        // hit after a false start
    push_text(t);
    t = '{8'hFF, 8'h00};                      // text shorter than the needle
    push_text(t);
    drain();

    // All-ones registers: length 15 clamps to the full window.
    write_reg(REG_NEEDLE_BYTES, '1);
    write_reg(REG_NEEDLE_LENGTH, '1);
    t = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_text(t);
    drain();

    // Unknown indexes must not disturb the needle.
    write_reg(REG_SPARE, '0);
    write_reg(REG_TOP, '0);
    t = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_text(t);
    drain();

    // Random phases, each with its own needle; the sender pauses between them
    // until every result is back.
    for (int p = 0; p < 8; p++) begin
      if (p % 2 == 1) begin
        // Two-symbol needle: overlapping near-matches everywhere.
        a = 8'($urandom_range(255));
        b = a ^ (8'h01 << $urandom_range(7));
        for (int k = 0; k < NEEDLE_LANES; k++) ndl[8*k +: 8] = $urandom_range(1) ? a : b;
      end else begin
        ndl = {$urandom, $urandom};
      end
      lenw = {$urandom, $urandom};
      case (p)
        0:       lenw[LEN_W-1:0] = 4'd8;
        1:       lenw[LEN_W-1:0] = 4'd15;
        2:       lenw[LEN_W-1:0] = 4'd0;
        3:       lenw[LEN_W-1:0] = 4'd1;
        default: lenw[LEN_W-1:0] = 4'($urandom_range(15));
      endcase
      e = cap_len(lenw[LEN_W-1:0]);
      write_reg(REG_NEEDLE_BYTES, ndl);
      write_reg(REG_NEEDLE_LENGTH, lenw);
      calm = (p == 4);
      fed = 0;
      while (fed < 100) begin
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
        gen_text(n, ndl, e);
        fed += n;
      end
      drain();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    $display("checked %0d texts: %0d with a match, %0d over the length limit",
             texts_done, found_count, long_count);
    $display("applied %0d register writes, including unknown indexes", reg_writes);
    if (err_count == 0 && match_reports.size() == 0) begin
      $display("[substring_first_match_search_core] OK");
    end else begin
      $display("[substring_first_match_search_core] ERROR");
    end
    $finish;
  end

endmodule
